// ----- hw/rtl/isrt_pkg.sv -----
package isrt_pkg;

   localparam int STORE_DEPTH_DEFAULT = 32;
   localparam int VALUE_WIDTH         = 32;
   localparam int QUEUE_DEPTH         = 2;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sample_value;
      logic                          end_of_run;
   } item_type;

endpackage

// ----- hw/rtl/isrt_front.sv -----
module isrt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [isrt_pkg::VALUE_WIDTH-1:0] req_sample_value,
   input  logic                                req_end_of_run,
   output logic                                q_valid,
   input  logic                                q_ready,
   output isrt_pkg::item_type                  q_item
);

   localparam int PtrWidth   = $clog2(isrt_pkg::QUEUE_DEPTH);
   localparam int CountWidth = $clog2(isrt_pkg::QUEUE_DEPTH + 1);

   isrt_pkg::item_type          slot_ff [isrt_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]       fill_ff, fill_in;
   logic                        push, pop;

   assign req_ready = (fill_ff != CountWidth'(isrt_pkg::QUEUE_DEPTH));
   assign q_valid   = (fill_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(isrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(isrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].sample_value <= req_sample_value;
         slot_ff[wr_ptr_ff].end_of_run   <= req_end_of_run;
      end
   end

endmodule

// ----- hw/rtl/isrt_back.sv -----
module isrt_back #(
   parameter int STORE_DEPTH = isrt_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_valid,
   output logic                                    q_ready,
   input  isrt_pkg::item_type                      q_item,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [isrt_pkg::VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                                    rsp_final_result,
   output logic                                    rsp_dropped_flag
);

   localparam int CountWidth = $clog2(STORE_DEPTH + 1);

   typedef enum logic {
      INSERT,
      DRAIN
   } mode_type;

   mode_type                             mode_ff, mode_in;
   logic signed [isrt_pkg::VALUE_WIDTH-1:0] cell_ff [STORE_DEPTH];
   logic signed [isrt_pkg::VALUE_WIDTH-1:0] ins_in  [STORE_DEPTH];
   logic signed [isrt_pkg::VALUE_WIDTH-1:0] drn_in  [STORE_DEPTH];
   logic [STORE_DEPTH-1:0]               gt;
   logic [STORE_DEPTH-1:0]               take;
   logic [CountWidth-1:0]                count_ff, count_in;
   logic                                 overflow_ff, overflow_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [isrt_pkg::VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                                 rsp_final_ff, rsp_final_in;
   logic                                 rsp_drop_ff, rsp_drop_in;
   logic                                 pop, full, load, last_out;

   assign q_ready = (mode_ff == INSERT);
   assign pop     = q_valid && q_ready;
   assign full    = (count_ff == CountWidth'(STORE_DEPTH));
   assign load    = (mode_ff == DRAIN) && (!rsp_valid_ff || rsp_ready);
   assign last_out = (count_ff == CountWidth'(1));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_result = rsp_final_ff;
   assign rsp_dropped_flag = rsp_drop_ff;

   // each cell compares the new value against its own content in parallel
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      assign gt[i]   = (CountWidth'(i) < count_ff) && (cell_ff[i] > q_item.sample_value);
      assign take[i] = gt[i] || (CountWidth'(i) == count_ff);
      if (i == 0) begin : g_head
         assign ins_in[i] = take[i] ? q_item.sample_value : cell_ff[i];
      end else begin : g_body
         assign ins_in[i] = !take[i] ? cell_ff[i] :
                            gt[i-1]  ? cell_ff[i-1] : q_item.sample_value;
      end
      if (i == STORE_DEPTH - 1) begin : g_tail
         assign drn_in[i] = cell_ff[i];
      end else begin : g_shift
         assign drn_in[i] = cell_ff[i+1];
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_drop_in  = rsp_drop_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (mode_ff)
         INSERT: begin
            if (pop) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (q_item.end_of_run) begin
                  mode_in = DRAIN;
               end
            end
         end
         DRAIN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = cell_ff[0];
               rsp_final_in = last_out;
               rsp_drop_in  = overflow_ff;
               count_in     = count_ff - 1'b1;
               if (last_out) begin
                  overflow_in = 1'b0;
                  mode_in     = INSERT;
               end
            end
         end
         default: begin
            mode_in = INSERT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= INSERT;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
      rsp_drop_ff  <= rsp_drop_in;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (pop && !full) begin
            cell_ff[i] <= ins_in[i];
         end else if (load) begin
            cell_ff[i] <= drn_in[i];
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(STORE_DEPTH))
      else $error("held count beyond store depth");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == DRAIN) |-> (count_ff != '0))
      else $error("draining an empty store");

   a_run_closes: assert property (@(posedge clock) disable iff (reset)
      (load && last_out) |=> (count_ff == '0 && !overflow_ff && mode_ff == INSERT))
      else $error("store not emptied after final beat");

   a_no_pop_in_drain: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == DRAIN) |-> !q_ready)
      else $error("queue popped while draining");

endmodule

// ----- hw/rtl/insertion_sorter_core.sv -----
// Stable insertion sorter for runs of signed 32-bit values.
//
// Input channel (req_): one value per beat, req_end_of_run high on the last
// value of a run. Beats pass a two-entry queue into a chain of STORE_DEPTH
// compare-and-shift cells, one value per cycle while filling. Equal values
// keep their arrival order. Values past STORE_DEPTH are dropped and flagged.
//
// Result channel (rsp_): once the marked beat is in the chain, the run leaves
// in ascending order, one beat per cycle while rsp_ready is high, from a
// registered output stage, rsp_final_result on the last beat and
// rsp_dropped_flag on every beat of a run that lost values. The first result
// follows the marked beat through queue, cell update and output register.
//
// Throughput: one input beat per cycle while a run fills; a run's held values
// then drain, during which the chain takes no new values and only the queue
// keeps accepting. A stalled receiver holds the output register and the
// drain, and the queue fills in turn.
//
// Reset clears the queue, the held count, the overflow mark and the output
// valid; cell contents are not cleared.
module insertion_sorter_core #(
   parameter int STORE_DEPTH = isrt_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [isrt_pkg::VALUE_WIDTH-1:0] req_sample_value,
   input  logic                                    req_end_of_run,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [isrt_pkg::VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                                    rsp_final_result,
   output logic                                    rsp_dropped_flag
);

   logic               q_valid;
   logic               q_ready;
   isrt_pkg::item_type q_item;

   isrt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_end_of_run   (req_end_of_run),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_item           (q_item)
   );

   isrt_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_item           (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_dropped_flag (rsp_dropped_flag)
   );

endmodule

// ----- dv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = isrt_pkg::STORE_DEPTH_DEFAULT;
   localparam int HOLD_OFF       = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   typedef logic signed [isrt_pkg::VALUE_WIDTH-1:0] word_type;

   typedef struct {
      word_type value;
      logic     last_beat;
      logic     dropped;
   } sorted_beat_type;

   localparam word_type WORD_MIN = {1'b1, {(isrt_pkg::VALUE_WIDTH-1){1'b0}}};
   localparam word_type WORD_MAX = {1'b0, {(isrt_pkg::VALUE_WIDTH-1){1'b1}}};

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_sample_value = '0;
   logic     req_end_of_run = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_sorted_value;
   logic     rsp_final_result;
   logic     rsp_dropped_flag;

   // Own copy of the sorter state
   word_type sorted_copy [DEPTH];
   int    copy_count = 0;
   bit    copy_overflow = 1'b0;
   sorted_beat_type pending_sorted [$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_stall_request = 0;
   int rx_hold_left = 0;
   int stuck_cycles = 0;

   int error_count = 0;
   int values_sent = 0;
   int runs_sent = 0;
   int overflow_runs = 0;
   int beats_checked = 0;

   insertion_sorter_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_end_of_run   (req_end_of_run),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_dropped_flag (rsp_dropped_flag)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Insert behind every held value <= v; on the marked beat emit the whole run.
   function automatic void sort_into_copy(input word_type v, input logic last);
      int pos;
      sorted_beat_type beat;
      if (copy_count >= DEPTH) begin
         copy_overflow = 1'b1;
      end else begin
         pos = copy_count;
         while (pos > 0 && sorted_copy[pos-1] > v) pos--;
         for (int k = copy_count; k > pos; k--) sorted_copy[k] = sorted_copy[k-1];
         sorted_copy[pos] = v;
         copy_count++;
      end
      if (last) begin
         for (int k = 0; k < copy_count; k++) begin
            beat.value     = sorted_copy[k];
            beat.last_beat = (k == copy_count - 1);
            beat.dropped   = copy_overflow;
            pending_sorted.push_back(beat);
         end
         runs_sent++;
         if (copy_overflow) overflow_runs++;
         copy_count    = 0;
         copy_overflow = 1'b0;
      end
   endfunction

   // Called at a rising edge; returns at the edge where the beat is taken.
   task automatic send_value(input word_type value, input logic last);
      if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      req_end_of_run   <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      sort_into_copy(value, last);
      values_sent++;
   endtask

   task automatic send_list(input word_type vals [$]);
      foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
   endtask

   function automatic word_type random_value();
      word_type picks [7];
      picks = '{WORD_MIN, WORD_MAX, 0, -1, 1, WORD_MIN + 1, WORD_MAX - 1};
      case ($urandom_range(0, 9))
         6, 7:    return word_type'(int'($urandom_range(0, 16)) - 8);
         8, 9:    return picks[$urandom_range(0, 6)];
         default: return word_type'($urandom);
      endcase
   endfunction

   // Mostly short runs, a fair share up to the store depth, a few that overflow.
   function automatic int run_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return $urandom_range(1, 8);
      if (r < 18) return $urandom_range(9, DEPTH);
      return $urandom_range(DEPTH + 1, DEPTH + 8);
   endfunction

   task automatic send_run(input int len);
      for (int i = 0; i < len; i++) send_value(random_value(), i == len - 1);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sorted.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_runs();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_list('{0});
      send_list('{WORD_MIN});
      send_list('{WORD_MAX, WORD_MIN, 0, -1, 1, WORD_MIN + 1, WORD_MAX - 1, 0});
      send_list('{5, 5, 5});
      send_list('{3, 2, 1, 0, -1});
   endtask

   // Exactly full, marked beat meeting a full store, and well past full.
   task automatic test_store_overflow();
      tx_idle_pct = 10;
      rx_idle_pct = 10;
      send_run(DEPTH);
      send_run(DEPTH + 1);
      send_run(DEPTH + 8);
   endtask

   task automatic test_input_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_stall_request = HOLD_OFF;
      send_run(24);
      send_run(24);
   endtask

   task automatic test_sender_pause();
      tx_idle_pct = 15;
      rx_idle_pct = 25;
      send_run(7);
      wait_for_drain();
      send_run(3);
   endtask

   task automatic test_random_runs(input int count);
      int target;
      int pcts [4];
      pcts   = '{0, 10, 30, 60};
      target = values_sent + count;
      while (values_sent < target) begin
         if ($urandom_range(0, 3) == 0) begin
            tx_idle_pct = pcts[$urandom_range(0, 3)];
            rx_idle_pct = pcts[$urandom_range(0, 3)];
         end
         send_run(run_length());
         if ($urandom_range(0, 7) == 0) wait_for_drain();
      end
   endtask

   task automatic test_no_idle_runs(input int count);
      int target;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      target = values_sent + count;
      while (values_sent < target) send_run(run_length());
   endtask

   // Receiver: random stall bursts plus the long hold-off on request.
   always @(posedge clock) begin
      if (rx_stall_request > 0) begin
         rx_hold_left     = rx_stall_request;
         rx_stall_request = 0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
         rx_hold_left = $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         beats_checked++;
         if (pending_sorted.size() == 0) begin
            report_mismatch($sformatf("unexpected beat value %0d", rsp_sorted_value));
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_sorted_value !== want.value)
               report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                         rsp_sorted_value, want.value));
            if (rsp_final_result !== want.last_beat)
               report_mismatch($sformatf("final_result %b, expected %b on value %0d",
                                         rsp_final_result, want.last_beat, want.value));
            if (rsp_dropped_flag !== want.dropped)
               report_mismatch($sformatf("dropped_flag %b, expected %b on value %0d",
                                         rsp_dropped_flag, want.dropped, want.value));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_runs();
      test_store_overflow();
      test_input_backpressure();
      test_sender_pause();
      test_random_runs(260);
      test_no_idle_runs(40);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_sorted.size() != 0)
         report_mismatch($sformatf("%0d sorted beats never arrived", pending_sorted.size()));
      $display("Sorted %0d values in %0d runs, %0d of them overflowing the %0d-entry store.",
               values_sent, runs_sent, overflow_runs, DEPTH);
      $display("Checked %0d beats under random idling, a %0d-cycle hold-off and an idle-free tail.",
               beats_checked, HOLD_OFF);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
